// ===== rtl/core/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the alias login and verify responder:
// field widths, command codes, frame type and MTI values.
// ----------------------------------------------------------------------------
package lcc_pkg;

    // field widths
    localparam int IdW     = 29;
    localparam int AliasW  = 12;
    localparam int NodeW   = 48;
    localparam int TailW   = 8;
    localparam int ByteW   = 8;
    localparam int LenW    = 4;
    localparam int PayW    = 64;
    localparam int MtiW    = 12;
    localparam int StepW   = 4;
    localparam int CfgIdxW = 2;

    // default depth of the command queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_ALIAS    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_IDENTITY = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PTAIL    = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_CTAIL    = 2'd3;

    // register reset values
    localparam logic [AliasW-1:0] ALIAS_RESET = 12'd1;

    // top five bits of the identifier
    localparam logic [4:0] FT_CHECK7 = 5'h17;
    localparam logic [4:0] FT_CHECK6 = 5'h16;
    localparam logic [4:0] FT_CHECK5 = 5'h15;
    localparam logic [4:0] FT_CHECK4 = 5'h14;
    localparam logic [4:0] FT_CTRL   = 5'h10;
    localparam logic [4:0] FT_MSG    = 5'h19;

    // control frame codes and message type indicators
    localparam logic [MtiW-1:0] CTRL_RID         = 12'h700;
    localparam logic [MtiW-1:0] CTRL_AMD         = 12'h701;
    localparam logic [MtiW-1:0] MTI_INIT_DONE    = 12'h100;
    localparam logic [MtiW-1:0] MTI_PRODUCER_ID  = 12'h547;
    localparam logic [MtiW-1:0] MTI_CONSUMER_ID  = 12'h4C7;
    localparam logic [MtiW-1:0] MTI_VERIFY_ADDR  = 12'h488;
    localparam logic [MtiW-1:0] MTI_VERIFY_GLOBAL = 12'h490;
    localparam logic [MtiW-1:0] MTI_VERIFIED     = 12'h170;

    // data lengths
    localparam logic [LenW-1:0] LEN_NODE  = 4'd6;
    localparam logic [LenW-1:0] LEN_EVENT = 4'd8;
    localparam logic [LenW-1:0] LEN_ADDR_MIN = 4'd2;

    // last step of the login sequence
    localparam logic [StepW-1:0] LAST_STEP = 4'd8;

    // command handed from front end to back end
    typedef enum logic [1:0] {
        CMD_LOGIN,
        CMD_REFUSE,
        CMD_VERIFY
    } cmd_t;

    // configuration as seen by both ends
    typedef struct packed {
        logic [AliasW-1:0] node_alias;
        logic [NodeW-1:0]  node_identity;
        logic [TailW-1:0]  producer_tail;
        logic [TailW-1:0]  consumer_tail;
    } cfg_t;

    // queue status towards its users
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/core/lcc_if.sv =====
// ----------------------------------------------------------------------------
// lcc_if
// Valid/ready channels of the responder: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface lcc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [lcc_pkg::IdW-1:0]       rx_identifier;
    logic [lcc_pkg::ByteW-1:0]     rx_byte0;
    logic [lcc_pkg::ByteW-1:0]     rx_byte1;
    logic [lcc_pkg::LenW-1:0]      rx_length;

    modport source (output valid, operation, rx_identifier, rx_byte0, rx_byte1,
                    rx_length, input ready);
    modport sink   (input valid, operation, rx_identifier, rx_byte0, rx_byte1,
                    rx_length, output ready);
endinterface

interface lcc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lcc_pkg::IdW-1:0]       frame_id;
    logic [lcc_pkg::LenW-1:0]      data_length;
    logic [lcc_pkg::PayW-1:0]      payload;
    logic                          last;
    logic                          error;

    modport source (output valid, frame_id, data_length, payload, last, error,
                    input ready);
    modport sink   (input valid, frame_id, data_length, payload, last, error,
                    output ready);
endinterface

interface lcc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lcc_pkg::CfgIdxW-1:0]   index;
    logic [lcc_pkg::NodeW-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lcc_can_login_and_verify_responder.sv =====
// ----------------------------------------------------------------------------
// lcc_can_login_and_verify_responder
// OpenLCB CAN alias login sequencer and verify-node-ID responder.
// ----------------------------------------------------------------------------
// A request transfer is either a login (nine frames: four check-ID, reserve
// ID, alias map definition, initialization complete, producer identified,
// consumer identified) or a received frame, answered by one verified-node-ID
// frame for a global verify or an addressed verify naming this alias. A
// login with alias zero gives one frame flagged as error, and received
// frames needing no answer are taken and dropped. The back-end sequencer
// sends one frame per cycle while the response channel is ready, so a login
// holds it for nine frames and a verify or refused login for one; the
// request queue of QueueDepth commands takes new requests every cycle while
// it has room, and frames leave through a registered response stage.
// Configuration writes are always taken and must only be made while idle.
// ----------------------------------------------------------------------------
module lcc_can_login_and_verify_responder #(
    parameter int QueueDepth = lcc_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    lcc_req_if.sink   req,
    lcc_rsp_if.source rsp,
    lcc_cfg_if.sink   cfg
);
    import lcc_pkg::*;

    cfg_t    cfg_reg;
    q_stat_t qstat;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head_cmd;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_alias    <= ALIAS_RESET;
            cfg_reg.node_identity <= '0;
            cfg_reg.producer_tail <= '0;
            cfg_reg.consumer_tail <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_ALIAS:    cfg_reg.node_alias    <= cfg.data[AliasW-1:0];
                REG_IDENTITY: cfg_reg.node_identity <= cfg.data;
                REG_PTAIL:    cfg_reg.producer_tail <= cfg.data[TailW-1:0];
                REG_CTAIL:    cfg_reg.consumer_tail <= cfg.data[TailW-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end: accept and classify
    lcc_front u_front (
        .req      (req),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue
    lcc_cmd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    // back end: frame sequencer
    lcc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .head_cmd (head_cmd),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/core/lcc_front.sv =====
// ----------------------------------------------------------------------------
// lcc_front
// Accepts request transfers and classifies them into login, refused login
// or verify commands; frames that need no answer are taken and dropped.
// ----------------------------------------------------------------------------
module lcc_front (
    lcc_req_if.sink          req,
    input  lcc_pkg::cfg_t    cfg,
    input  lcc_pkg::q_stat_t qstat,
    output logic             push,
    output lcc_pkg::cmd_t    push_cmd
);
    import lcc_pkg::*;

    logic [MtiW-1:0] mti;
    logic            is_msg;
    logic            addr_hit;
    logic            answer;

    // take a transfer whenever the queue has room
    assign req.ready = !qstat.full;

    // decode of a received frame
    assign mti      = req.rx_identifier[2*AliasW-1:AliasW];
    assign is_msg   = (req.rx_identifier[IdW-1:IdW-5] == FT_MSG);
    assign addr_hit = (req.rx_length >= LEN_ADDR_MIN) &&
                      ({req.rx_byte0, req.rx_byte1} ==
                       {{(2*ByteW-AliasW){1'b0}}, cfg.node_alias});
    assign answer   = is_msg && ((mti == MTI_VERIFY_GLOBAL) ||
                                 ((mti == MTI_VERIFY_ADDR) && addr_hit));

    // command selection
    always_comb
    begin
        push_cmd = CMD_VERIFY;
        push     = 1'b0;
        if (!req.operation)
        begin
            push_cmd = (cfg.node_alias == '0) ? CMD_REFUSE : CMD_LOGIN;
            push     = req.valid && req.ready;
        end
        else
        begin
            push = req.valid && req.ready && answer;
        end
    end

endmodule

// ===== rtl/core/lcc_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// lcc_cmd_queue
// Short command queue that decouples the front end from the frame
// sequencer in the back end.
// ----------------------------------------------------------------------------
module lcc_cmd_queue #(
    parameter int Depth = lcc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lcc_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output lcc_pkg::cmd_t     head_cmd,
    output lcc_pkg::q_stat_t  qstat
);
    import lcc_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    cmd_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == CntFull);
    assign qstat.empty = (count_reg == '0);
    assign head_cmd    = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntFull)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/lcc_back.sv =====
// ----------------------------------------------------------------------------
// lcc_back
// Frame sequencer: steps through the frames of the command at the queue
// head into a registered response stage, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module lcc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lcc_pkg::cfg_t    cfg,
    input  lcc_pkg::q_stat_t qstat,
    input  lcc_pkg::cmd_t    head_cmd,
    output logic             pop,
    lcc_rsp_if.source        rsp
);
    import lcc_pkg::*;

    logic [StepW-1:0]  step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [IdW-1:0]    frame_id_reg;
    logic [LenW-1:0]   data_length_reg;
    logic [PayW-1:0]   payload_reg;
    logic              last_reg;
    logic              error_reg;

    logic              can_load;
    logic              issue;
    logic [IdW-1:0]    fr_id;
    logic [LenW-1:0]   fr_len;
    logic [PayW-1:0]   fr_pay;
    logic              fr_last;
    logic              fr_err;
    logic [PayW-1:0]   node_pay;
    logic [AliasW-1:0] a;
    logic [NodeW-1:0]  n;

    assign a        = cfg.node_alias;
    assign n        = cfg.node_identity;
    assign node_pay = {n, {(PayW-NodeW){1'b0}}};

    // frame for the current command and step
    always_comb
    begin
        fr_id   = '0;
        fr_len  = '0;
        fr_pay  = '0;
        fr_last = 1'b0;
        fr_err  = 1'b0;
        unique case (head_cmd)
            CMD_REFUSE:
            begin
                fr_last = 1'b1;
                fr_err  = 1'b1;
            end
            CMD_VERIFY:
            begin
                fr_id   = {FT_MSG, MTI_VERIFIED, a};
                fr_len  = LEN_NODE;
                fr_pay  = node_pay;
                fr_last = 1'b1;
            end
            CMD_LOGIN:
            begin
                unique case (step_reg)
                    4'd0: fr_id = {FT_CHECK7, n[47:36], a};
                    4'd1: fr_id = {FT_CHECK6, n[35:24], a};
                    4'd2: fr_id = {FT_CHECK5, n[23:12], a};
                    4'd3: fr_id = {FT_CHECK4, n[11:0], a};
                    4'd4: fr_id = {FT_CTRL, CTRL_RID, a};
                    4'd5:
                    begin
                        fr_id  = {FT_CTRL, CTRL_AMD, a};
                        fr_len = LEN_NODE;
                        fr_pay = node_pay;
                    end
                    4'd6:
                    begin
                        fr_id  = {FT_MSG, MTI_INIT_DONE, a};
                        fr_len = LEN_NODE;
                        fr_pay = node_pay;
                    end
                    4'd7:
                    begin
                        fr_id  = {FT_MSG, MTI_PRODUCER_ID, a};
                        fr_len = LEN_EVENT;
                        fr_pay = {n, {ByteW{1'b0}}, cfg.producer_tail};
                    end
                    4'd8:
                    begin
                        fr_id   = {FT_MSG, MTI_CONSUMER_ID, a};
                        fr_len  = LEN_EVENT;
                        fr_pay  = {n, {ByteW{1'b0}}, cfg.consumer_tail};
                        fr_last = 1'b1;
                    end
                    default: fr_last = 1'b1;
                endcase
            end
            default: fr_last = 1'b1;
        endcase
    end

    // issue when the response stage is free or being drained
    assign can_load  = !out_valid_reg || rsp.ready;
    assign issue     = !qstat.empty && can_load;
    assign pop       = issue && fr_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            step_next      = fr_last ? '0 : step_reg + 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // response payload register
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            frame_id_reg    <= fr_id;
            data_length_reg <= fr_len;
            payload_reg     <= fr_pay;
            last_reg        <= fr_last;
            error_reg       <= fr_err;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.frame_id    = frame_id_reg;
    assign rsp.data_length = data_length_reg;
    assign rsp.payload     = payload_reg;
    assign rsp.last        = last_reg;
    assign rsp.error       = error_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("login step out of range");

    a_step_login: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> (!qstat.empty && head_cmd == CMD_LOGIN))
        else $error("login step without login at queue head");

    a_step_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && fr_last) |=> (step_reg == '0))
        else $error("step not cleared after last frame");

endmodule
